/* sv/fsig_pkg.sv */
// Shared types and constants for the floppy format sector ID generator.
// Used by fsig_alu, fsig_seq and the top level; depends on nothing else.
`default_nettype none

package fsig_pkg;

  // Supported sector counts per track.
  localparam logic [4:0] SPT_FORMAT_A = 5'd18;
  localparam logic [4:0] SPT_FORMAT_B = 5'd21;

  // Configuration register indexes and reset values.
  localparam logic CFG_IDX_SPT   = 1'b0;
  localparam logic CFG_IDX_HEADS = 1'b1;
  localparam logic [4:0] SPT_RESET   = 5'd18;
  localparam logic [1:0] HEADS_RESET = 2'd2;

  // Size code 2 means 512-byte sectors.
  localparam logic [1:0] SIZE_CODE_512 = 2'd2;

  // Skew applied on odd heads.
  localparam logic signed [6:0] HEAD_SKEW = 7'sd2;

  typedef logic signed [6:0] sval_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OFF_E,
    S_OFF_O,
    S_EMIT,
    S_ERR
  } fsig_state_t;

  // Operand bundle for the shared adder.
  typedef struct packed {
    sval_t a;
    sval_t b;
    logic  cin;
    logic  wrap;
  } alu_req_t;

endpackage

`default_nettype wire

/* sv/fsig_alu.sv */
// Shared adder with optional wrap of the sum into 1..n.
// Depends on fsig_pkg for the operand struct and value type.
`default_nettype none

module fsig_alu
  import fsig_pkg::*;
(
  input  wire alu_req_t   req,
  input  wire logic [4:0] n,
  output sval_t           res
);

  sval_t sum;
  sval_t n_s;

  always_comb begin
    n_s = $signed({2'b00, n});
    sum = req.a + req.b + $signed({6'b000000, req.cin});
    res = sum;
    if (req.wrap) begin
      if (sum < 7'sd1) begin
        res = sum + n_s;
      end else if (sum > n_s) begin
        res = sum - n_s;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/fsig_seq.sv */
// Sequencer for the sector ID generator: walks heads and sector slots,
// drives the shared adder and holds the output register. Depends on fsig_pkg.
`default_nettype none

module fsig_seq
  import fsig_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [4:0] spt_cfg,
  input  wire logic [1:0] heads_cfg,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_track_number,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_id_track,
  output logic            out_id_head,
  output logic [4:0]      out_id_sector,
  output logic [1:0]      out_id_size_code,
  output logic            out_bad_geometry,
  output logic            out_head_done,
  output logic            out_last,
  output alu_req_t        alu_req,
  output logic [4:0]      alu_n,
  input  wire sval_t      alu_res
);

  fsig_state_t state_r, state_nxt;
  logic [4:0]  slot_r, slot_nxt;
  logic        head_r, head_nxt;
  logic [7:0]  track_r, track_nxt;
  logic [4:0]  spt_r, spt_nxt;
  logic        two_heads_r, two_heads_nxt;
  sval_t       off_e_r, off_e_nxt;
  sval_t       off_o_r, off_o_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_track_r, out_track_nxt;
  logic        out_head_r, out_head_nxt;
  logic [4:0]  out_sector_r, out_sector_nxt;
  logic [1:0]  out_size_r, out_size_nxt;
  logic        out_bad_r, out_bad_nxt;
  logic        out_hd_r, out_hd_nxt;
  logic        out_last_r, out_last_nxt;

  logic        out_free;
  logic        in_accept;
  logic        spt_ok;
  logic        hd;
  logic [5:0]  split;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign spt_ok    = (spt_cfg == SPT_FORMAT_A) || (spt_cfg == SPT_FORMAT_B);
  assign hd        = (slot_r == (spt_r - 5'd1));
  assign split     = ({1'b0, spt_r} + 6'd1) >> 1;
  assign alu_n     = spt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= 5'd0;
      head_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    track_r      <= track_nxt;
    spt_r        <= spt_nxt;
    two_heads_r  <= two_heads_nxt;
    off_e_r      <= off_e_nxt;
    off_o_r      <= off_o_nxt;
    out_track_r  <= out_track_nxt;
    out_head_r   <= out_head_nxt;
    out_sector_r <= out_sector_nxt;
    out_size_r   <= out_size_nxt;
    out_bad_r    <= out_bad_nxt;
    out_hd_r     <= out_hd_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    head_nxt       = head_r;
    track_nxt      = track_r;
    spt_nxt        = spt_r;
    two_heads_nxt  = two_heads_r;
    off_e_nxt      = off_e_r;
    off_o_nxt      = off_o_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_track_nxt  = out_track_r;
    out_head_nxt   = out_head_r;
    out_sector_nxt = out_sector_r;
    out_size_nxt   = out_size_r;
    out_bad_nxt    = out_bad_r;
    out_hd_nxt     = out_hd_r;
    out_last_nxt   = out_last_r;
    alu_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          track_nxt     = in_track_number;
          spt_nxt       = spt_cfg;
          two_heads_nxt = (heads_cfg >= 2'd2);
          head_nxt      = 1'b0;
          slot_nxt      = 5'd0;
          state_nxt     = spt_ok ? S_OFF_E : S_ERR;
        end
      end
      S_OFF_E: begin
        alu_req.a = head_r ? -HEAD_SKEW : 7'sd0;
        alu_req.b = track_r[0] ? (7'sd0 - $signed({3'b000, spt_r[4:1]})) : 7'sd0;
        off_e_nxt = alu_res;
        state_nxt = S_OFF_O;
      end
      S_OFF_O: begin
        alu_req.a = off_e_r;
        alu_req.b = $signed({1'b0, split});
        off_o_nxt = alu_res;
        slot_nxt  = 5'd0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        alu_req.a    = $signed({3'b000, slot_r[4:1]});
        alu_req.b    = slot_r[0] ? off_o_r : off_e_r;
        alu_req.cin  = 1'b1;
        alu_req.wrap = 1'b1;
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_track_nxt  = track_r;
          out_head_nxt   = head_r;
          out_sector_nxt = alu_res[4:0];
          out_size_nxt   = SIZE_CODE_512;
          out_bad_nxt    = 1'b0;
          out_hd_nxt     = hd;
          out_last_nxt   = hd && (head_r == two_heads_r);
          if (hd) begin
            slot_nxt = 5'd0;
            if (head_r == two_heads_r) begin
              head_nxt  = 1'b0;
              state_nxt = S_IDLE;
            end else begin
              head_nxt  = 1'b1;
              state_nxt = S_OFF_E;
            end
          end else begin
            slot_nxt = slot_r + 5'd1;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_track_nxt  = 8'd0;
          out_head_nxt   = 1'b0;
          out_sector_nxt = 5'd0;
          out_size_nxt   = 2'd0;
          out_bad_nxt    = 1'b1;
          out_hd_nxt     = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_id_track     = out_track_r;
  assign out_id_head      = out_head_r;
  assign out_id_sector    = out_sector_r;
  assign out_id_size_code = out_size_r;
  assign out_bad_geometry = out_bad_r;
  assign out_head_done    = out_hd_r;
  assign out_last         = out_last_r;

  // A generated sector ID always lands in 1..spt.
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (alu_res >= 7'sd1 && alu_res <= $signed({2'b00, spt_r})))
    else $error("sector ID out of range");

  // An accepted transaction always starts a sequence.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start a sequence");

  // The error result is the only result of its transaction.
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> out_last_r)
    else $error("error result not marked last");

  // The final result of a track also ends its head.
  a_last_ends_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && !out_bad_r) |-> out_hd_r)
    else $error("last result without head_done");

endmodule

`default_nettype wire

/* sv/floppy_format_sector_id_generator.sv */
// Top level of the floppy format sector ID generator: configuration
// registers, sequencer and shared adder. Depends on fsig_pkg, fsig_alu, fsig_seq.
//
// Usage: write sectors_per_track (index 0) and head_count (index 1) on the
// cfg port while the block is idle. Each input transaction carries a track
// number. For each head in turn the block returns one transaction per sector
// slot with the track, head, interleaved and skewed sector ID and size code 2;
// head_done marks the last sector of a head and last marks the final result.
// An unsupported sector count gives a single result with bad_geometry set.
// While a track is in progress in_stall stays high, so a new track is taken
// only once the last one is done. For each head the shared adder first
// sets up the even and odd offsets (S_OFF_E, S_OFF_O), then gives one sector
// ID per cycle while the output is free to take it. The first result
// is registered in the output register after S_OFF_E and S_OFF_O.
// When out_stall is high while a result is valid, the output register holds
// it and the sequencer waits. Reset clears the sequencer and output valid and
// restores sectors_per_track to 18 and head_count to 2.
`default_nettype none

module floppy_format_sector_id_generator
  import fsig_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic [4:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_track_number,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_id_track,
  output logic            out_id_head,
  output logic [4:0]      out_id_sector,
  output logic [1:0]      out_id_size_code,
  output logic            out_bad_geometry,
  output logic            out_head_done,
  output logic            out_last
);

  logic [4:0] spt_r, spt_nxt;
  logic [1:0] heads_r, heads_nxt;
  alu_req_t   alu_req;
  logic [4:0] alu_n;
  sval_t      alu_res;

  always_comb begin
    spt_nxt   = spt_r;
    heads_nxt = heads_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_SPT:   spt_nxt   = cfg_wdata;
        CFG_IDX_HEADS: heads_nxt = cfg_wdata[1:0];
        default: begin
          spt_nxt = spt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r   <= SPT_RESET;
      heads_r <= HEADS_RESET;
    end else begin
      spt_r   <= spt_nxt;
      heads_r <= heads_nxt;
    end
  end

  fsig_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .spt_cfg          (spt_r),
    .heads_cfg        (heads_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_track_number  (in_track_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_id_track     (out_id_track),
    .out_id_head      (out_id_head),
    .out_id_sector    (out_id_sector),
    .out_id_size_code (out_id_size_code),
    .out_bad_geometry (out_bad_geometry),
    .out_head_done    (out_head_done),
    .out_last         (out_last),
    .alu_req          (alu_req),
    .alu_n            (alu_n),
    .alu_res          (alu_res)
  );

  fsig_alu u_alu (
    .req (alu_req),
    .n   (alu_n),
    .res (alu_res)
  );

endmodule

`default_nettype wire
